/* rtl/priority_task_table_scheduler_core_macros.svh */
// Assertion macros for the priority task table scheduler.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef PRIORITY_TASK_TABLE_SCHEDULER_CORE_MACROS_SVH
`define PRIORITY_TASK_TABLE_SCHEDULER_CORE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define PTTS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in one cycle implies a condition in the next.
`define PTTS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/ptts_pkg.sv */
// Shared constants, codes and types of the priority task table scheduler.
// No dependencies.
package ptts_pkg;

  localparam int MAX_TASKS  = 8;
  localparam int PRIO_BITS  = 8;
  localparam int ENTRY_BITS = 32;

  localparam int SLOT_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W    = $clog2(MAX_TASKS + 1);
  localparam int ACT_W    = 3;
  localparam int ID_W     = 3;
  localparam int STATUS_W = 3;

  // Request actions
  localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SUSPEND = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RESUME  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PICK    = 3'd4;

  // Result status
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_PRIO = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_DUP_PRIO = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_ID   = 3'd4;

  // Per-slot task state
  localparam logic [1:0] TS_READY     = 2'd0;
  localparam logic [1:0] TS_DELETED   = 2'd1;
  localparam logic [1:0] TS_SUSPENDED = 2'd2;

  typedef struct packed {
    logic [1:0]           state;
    logic [1:0]           saved;
    logic [PRIO_BITS-1:0] prio;
  } ctl_t;

  localparam int CTL_W = $bits(ctl_t);

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    ctl_t              wdata;
    logic [SLOT_W-1:0] raddr;
  } ctl_port_t;

  typedef struct packed {
    logic                  we;
    logic [SLOT_W-1:0]     waddr;
    logic [ENTRY_BITS-1:0] wdata;
    logic [SLOT_W-1:0]     raddr;
  } entry_port_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   handle;
    logic                found;
    logic [SLOT_W-1:0]   best;
  } result_t;

endpackage

/* rtl/ptts_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ptts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ptts_walk.sv */
// Request sequencer: walks the control RAM one slot a cycle, applies the
// action in place, checks for duplicate priority and tracks the best ready slot.
// Depends on ptts_pkg.
module ptts_walk (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ptts_pkg::ACT_W-1:0]    action_i,
  input  logic [ptts_pkg::ID_W-1:0]     task_id_i,
  input  logic [ptts_pkg::PRIO_BITS-1:0] priority_req_i,
  input  logic [ptts_pkg::ENTRY_BITS-1:0] entry_addr_i,
  input  ptts_pkg::ctl_t                ctl_rdata_i,
  output ptts_pkg::ctl_port_t           ctl_port_o,
  output ptts_pkg::entry_port_t         entry_port_o,
  output logic                          res_valid_o,
  input  logic                          res_take_i,
  output ptts_pkg::result_t             res_o
);

  import ptts_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_WALK    = 3'd1;
  localparam logic [2:0] S_COMMIT  = 3'd2;
  localparam logic [2:0] S_ENTRY   = 3'd3;
  localparam logic [2:0] S_CAPTURE = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [ACT_W-1:0]      act_q, act_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [PRIO_BITS-1:0]  prio_q, prio_d;
  logic [ENTRY_BITS-1:0] entry_q, entry_d;
  logic [SLOT_W-1:0]     chk_q, chk_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  dup_q, dup_d;
  logic                  found_q, found_d;
  logic [SLOT_W-1:0]     best_q, best_d;
  logic [PRIO_BITS-1:0]  best_prio_q, best_prio_d;
  logic [SLOT_W-1:0]     handle_q, handle_d;

  ctl_t  upd;
  logic  hit;
  logic  modify;

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_CAPTURE);
  assign modify      = (act_q == ACT_DELETE) || (act_q == ACT_SUSPEND) ||
                       (act_q == ACT_RESUME);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    act_d       = act_q;
    id_d        = id_q;
    prio_d      = prio_q;
    entry_d     = entry_q;
    chk_d       = chk_q;
    status_d    = status_q;
    dup_d       = dup_q;
    found_d     = found_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    handle_d    = handle_q;

    ctl_port_o.we    = 1'b0;
    ctl_port_o.waddr = chk_q;
    ctl_port_o.wdata = ctl_rdata_i;
    ctl_port_o.raddr = '0;

    entry_port_o.we    = 1'b0;
    entry_port_o.waddr = count_q[SLOT_W-1:0];
    entry_port_o.wdata = entry_q;
    entry_port_o.raddr = best_q;

    upd = ctl_rdata_i;
    hit = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d       = action_i;
          id_d        = task_id_i;
          prio_d      = priority_req_i;
          entry_d     = entry_addr_i;
          chk_d       = '0;
          dup_d       = 1'b0;
          found_d     = 1'b0;
          best_d      = '0;
          best_prio_d = '0;
          handle_d    = '0;
          status_d    = STAT_OK;
          if (action_i == ACT_CREATE) begin
            if (count_q == CNT_W'(MAX_TASKS)) begin
              status_d = STAT_FULL;
            end else if (priority_req_i == '0) begin
              status_d = STAT_BAD_PRIO;
            end
          end else if (action_i inside {ACT_DELETE, ACT_SUSPEND, ACT_RESUME}) begin
            if (CNT_W'(task_id_i) >= count_q) begin
              status_d = STAT_BAD_ID;
            end
          end
          state_d = (count_q == '0) ? S_COMMIT : S_WALK;
        end
      end

      S_WALK: begin
        // read data belongs to slot chk_q; fetch the next one
        ctl_port_o.raddr = SLOT_W'(chk_q + 1'b1);
        hit = (status_q == STAT_OK) && modify && (chk_q == SLOT_W'(id_q));
        case (act_q)
          ACT_DELETE: begin
            upd.state = TS_DELETED;
          end
          ACT_SUSPEND: begin
            upd.saved = ctl_rdata_i.state;
            upd.state = TS_SUSPENDED;
          end
          ACT_RESUME: begin
            upd.state = ctl_rdata_i.saved;
          end
          default: begin
            upd = ctl_rdata_i;
          end
        endcase
        if (!hit) begin
          upd = ctl_rdata_i;
        end
        ctl_port_o.we    = hit;
        ctl_port_o.waddr = chk_q;
        ctl_port_o.wdata = upd;

        if ((act_q == ACT_CREATE) && (ctl_rdata_i.prio == prio_q)) begin
          dup_d = 1'b1;
        end
        if ((upd.state == TS_READY) && (upd.prio > best_prio_q)) begin
          best_prio_d = upd.prio;
          best_d      = chk_q;
          found_d     = 1'b1;
        end
        if (CNT_W'(chk_q) == CNT_W'(count_q - 1'b1)) begin
          state_d = S_COMMIT;
        end else begin
          chk_d = SLOT_W'(chk_q + 1'b1);
        end
      end

      S_COMMIT: begin
        if ((act_q == ACT_CREATE) && (status_q == STAT_OK)) begin
          if (dup_q) begin
            status_d = STAT_DUP_PRIO;
          end else begin
            ctl_port_o.we          = 1'b1;
            ctl_port_o.waddr       = count_q[SLOT_W-1:0];
            ctl_port_o.wdata.state = TS_READY;
            ctl_port_o.wdata.saved = TS_READY;
            ctl_port_o.wdata.prio  = prio_q;
            entry_port_o.we        = 1'b1;
            handle_d               = count_q[SLOT_W-1:0];
            count_d                = CNT_W'(count_q + 1'b1);
            // new slot has the highest index, so it wins only on strictly higher priority
            if (prio_q > best_prio_q) begin
              best_d      = count_q[SLOT_W-1:0];
              best_prio_d = prio_q;
              found_d     = 1'b1;
            end
          end
        end
        state_d = S_ENTRY;
      end

      S_ENTRY: begin
        state_d = S_CAPTURE;
      end

      S_CAPTURE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    id_q        <= id_d;
    prio_q      <= prio_d;
    entry_q     <= entry_d;
    chk_q       <= chk_d;
    status_q    <= status_d;
    dup_q       <= dup_d;
    found_q     <= found_d;
    best_q      <= best_d;
    best_prio_q <= best_prio_d;
    handle_q    <= handle_d;
  end

  assign res_o.status = status_q;
  assign res_o.handle = handle_q;
  assign res_o.found  = found_q;
  assign res_o.best   = best_q;

endmodule

/* rtl/priority_task_table_scheduler_core.sv */
// Priority task table scheduler: create, delete, suspend, resume, pick.
// Items are handled one at a time; the next is accepted once the result is taken.
// The walk goes through the control RAM read port one slot per cycle.
// Reset clears the task count and control; slot RAMs are not cleared.
`include "priority_task_table_scheduler_core_macros.svh"

module priority_task_table_scheduler_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ptts_pkg::ACT_W-1:0]      action_i,
  input  logic [ptts_pkg::ID_W-1:0]       task_id_i,
  input  logic [ptts_pkg::PRIO_BITS-1:0]  priority_req_i,
  input  logic [ptts_pkg::ENTRY_BITS-1:0] entry_addr_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ptts_pkg::STATUS_W-1:0]   status_o,
  output logic [ptts_pkg::ID_W-1:0]       new_handle_o,
  output logic                            run_valid_o,
  output logic [ptts_pkg::ID_W-1:0]       run_task_o,
  output logic [ptts_pkg::ENTRY_BITS-1:0] run_entry_o
);

  import ptts_pkg::*;

  ctl_port_t             ctl_port;
  entry_port_t           entry_port;
  ctl_t                  ctl_rdata;
  logic [ENTRY_BITS-1:0] entry_rdata;
  result_t               res;
  logic                  res_valid;
  logic                  res_take;

  logic                  out_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [ID_W-1:0]       handle_q;
  logic                  run_valid_q;
  logic [ID_W-1:0]       run_task_q;
  logic [ENTRY_BITS-1:0] run_entry_q;

  ptts_ram #(
    .WIDTH (CTL_W),
    .DEPTH (MAX_TASKS)
  ) u_ctl_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_port.we),
    .waddr_i (ctl_port.waddr),
    .wdata_i (ctl_port.wdata),
    .raddr_i (ctl_port.raddr),
    .rdata_o (ctl_rdata)
  );

  ptts_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (MAX_TASKS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (entry_port.we),
    .waddr_i (entry_port.waddr),
    .wdata_i (entry_port.wdata),
    .raddr_i (entry_port.raddr),
    .rdata_o (entry_rdata)
  );

  ptts_walk u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .entry_addr_i   (entry_addr_i),
    .ctl_rdata_i    (ctl_rdata),
    .ctl_port_o     (ctl_port),
    .entry_port_o   (entry_port),
    .res_valid_o    (res_valid),
    .res_take_i     (res_take),
    .res_o          (res)
  );

  // load the output register when it is empty or being drained
  assign res_take = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      status_q    <= res.status;
      handle_q    <= ID_W'(res.handle);
      run_valid_q <= res.found;
      run_task_q  <= res.found ? ID_W'(res.best) : '0;
      run_entry_q <= res.found ? entry_rdata : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign new_handle_o = handle_q;
  assign run_valid_o  = run_valid_q;
  assign run_task_o   = run_task_q;
  assign run_entry_o  = run_entry_q;

  `PTTS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o,
    !in_ready_o, "item accepted while previous item still in flight")
  `PTTS_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, res_valid && res_take,
    out_valid_o, "finished result not presented")
  `PTTS_ASSERT(a_handle_on_fail, clk_i, rst_ni,
    !(out_valid_o && (status_o != STAT_OK)) || (new_handle_o == '0),
    "nonzero handle on failed request")
  `PTTS_ASSERT(a_no_ready_task, clk_i, rst_ni,
    !(out_valid_o && !run_valid_o) || ((run_task_o == '0) && (run_entry_o == '0)),
    "run fields nonzero with no ready task")

endmodule

/* sim/testbench.sv */
// Testbench for priority_task_table_scheduler_core: random and directed table requests,
// checked result by result against an in-bench prediction of the task table.
// Depends on ptts_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
  import ptts_pkg::*;

  localparam int CLK_HALF        = 10;
  localparam int RANDOM_ITEMS    = 1000;
  localparam int HOLDOFF_AT      = 150;   // results seen before the long receiver hold-off
  localparam int HOLDOFF_CYCLES  = 400;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 30;

  // codes 5 to 7 behave as pick only
  localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_UNUSED_MID   = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 3'd7;

  typedef struct {
    logic [ACT_W-1:0]      action;
    logic [ID_W-1:0]       task_id;
    logic [PRIO_BITS-1:0]  prio;
    logic [ENTRY_BITS-1:0] entry;
  } sched_req_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [ID_W-1:0]       handle;
    logic                  run_valid;
    logic [ID_W-1:0]       run_task;
    logic [ENTRY_BITS-1:0] run_entry;
  } sched_result_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [ACT_W-1:0]      action_i       = '0;
  logic [ID_W-1:0]       task_id_i      = '0;
  logic [PRIO_BITS-1:0]  priority_req_i = '0;
  logic [ENTRY_BITS-1:0] entry_addr_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [STATUS_W-1:0]   status_o;
  logic [ID_W-1:0]       new_handle_o;
  logic                  run_valid_o;
  logic [ID_W-1:0]       run_task_o;
  logic [ENTRY_BITS-1:0] run_entry_o;

  priority_task_table_scheduler_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .task_id_i      (task_id_i),
    .priority_req_i (priority_req_i),
    .entry_addr_i   (entry_addr_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .new_handle_o   (new_handle_o),
    .run_valid_o    (run_valid_o),
    .run_task_o     (run_task_o),
    .run_entry_o    (run_entry_o)
  );

  // predicted task table
  int                    tbl_count;
  logic [1:0]            tbl_state [MAX_TASKS];
  logic [1:0]            tbl_saved [MAX_TASKS];
  logic [PRIO_BITS-1:0]  tbl_prio  [MAX_TASKS];
  logic [ENTRY_BITS-1:0] tbl_entry [MAX_TASKS];

  // what the request generator knows of the table, to keep requests legal
  int gen_count;
  bit gen_prio_used [1 << PRIO_BITS];
  bit gen_suspended [MAX_TASKS];

  sched_req_t    req_queue[$];
  sched_result_t expected_results[$];
  sched_req_t    cur_req;

  int items_queued;
  int items_accepted;
  int results_seen;
  int mismatches;
  int idle_cycles;
  int tx_gap_left;
  int rx_stall_left;
  int holdoff_left;
  bit holdoff_done;
  bit tx_holding;
  bit tx_calm;
  bit rx_calm;

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Mostly short gaps, a few long ones, and calm stretches with none at all.
  function automatic int pick_gap(inout bit calm);
    int r;
    if ($urandom_range(0, 99) < 3) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Apply one request to the predicted table and return the result it yields.
  function automatic sched_result_t sched_apply(sched_req_t req);
    sched_result_t        res;
    logic [PRIO_BITS-1:0] best_prio;
    bit                   dup;
    res.status    = STAT_OK;
    res.handle    = '0;
    res.run_valid = 1'b0;
    res.run_task  = '0;
    res.run_entry = '0;
    case (req.action)
      ACT_CREATE: begin
        dup = 1'b0;
        for (int i = 0; i < tbl_count; i++)
          if (tbl_prio[i] == req.prio) dup = 1'b1;
        if (tbl_count >= MAX_TASKS) begin
          res.status = STAT_FULL;
        end else if (req.prio == '0) begin
          res.status = STAT_BAD_PRIO;
        end else if (dup) begin
          res.status = STAT_DUP_PRIO;
        end else begin
          tbl_state[tbl_count] = TS_READY;
          tbl_prio[tbl_count]  = req.prio;
          tbl_entry[tbl_count] = req.entry;
          res.handle = ID_W'(tbl_count);
          tbl_count++;
        end
      end
      ACT_DELETE, ACT_SUSPEND, ACT_RESUME: begin
        if (req.task_id >= tbl_count) begin
          res.status = STAT_BAD_ID;
        end else if (req.action == ACT_DELETE) begin
          tbl_state[req.task_id] = TS_DELETED;
        end else if (req.action == ACT_SUSPEND) begin
          tbl_saved[req.task_id] = tbl_state[req.task_id];
          tbl_state[req.task_id] = TS_SUSPENDED;
        end else begin
          tbl_state[req.task_id] = tbl_saved[req.task_id];
        end
      end
      default: ;
    endcase
    best_prio = '0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_state[i] == TS_READY && tbl_prio[i] > best_prio) begin
        best_prio     = tbl_prio[i];
        res.run_valid = 1'b1;
        res.run_task  = ID_W'(i);
        res.run_entry = tbl_entry[i];
      end
    end
    return res;
  endfunction

  function automatic void queue_req(logic [ACT_W-1:0] action, logic [ID_W-1:0] id,
                                    logic [PRIO_BITS-1:0] prio, logic [ENTRY_BITS-1:0] entry);
    sched_req_t req;
    req.action  = action;
    req.task_id = id;
    req.prio    = prio;
    req.entry   = entry;
    if (action == ACT_CREATE && gen_count < MAX_TASKS && prio != '0 && !gen_prio_used[prio]) begin
      gen_prio_used[prio] = 1'b1;
      gen_count++;
    end
    if (action == ACT_SUSPEND && id < gen_count) gen_suspended[id] = 1'b1;
    req_queue.push_back(req);
    items_queued++;
  endfunction

  function automatic void check_field(string name, logic [ENTRY_BITS-1:0] exp_v,
                                      logic [ENTRY_BITS-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Driver: present queued items with random gaps, hold each until accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(sched_apply(cur_req));
        items_accepted++;
        tx_holding = 1'b0;
      end else begin
        tx_holding = in_valid_i;
      end
      if (!tx_holding) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_valid_i <= 1'b0;
        end else if (req_queue.size() > 0) begin
          cur_req = req_queue.pop_front();
          action_i       <= cur_req.action;
          task_id_i      <= cur_req.task_id;
          priority_req_i <= cur_req.prio;
          entry_addr_i   <= cur_req.entry;
          in_valid_i     <= 1'b1;
          tx_gap_left = pick_gap(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result against the oldest expectation, stall at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t ns: result with nothing expected: status 0x%0h", $time, status_o);
        end else begin
          check_field("status", ENTRY_BITS'(expected_results[0].status),
                      ENTRY_BITS'(status_o));
          check_field("new_handle", ENTRY_BITS'(expected_results[0].handle),
                      ENTRY_BITS'(new_handle_o));
          check_field("run_valid", ENTRY_BITS'(expected_results[0].run_valid),
                      ENTRY_BITS'(run_valid_o));
          check_field("run_task", ENTRY_BITS'(expected_results[0].run_task),
                      ENTRY_BITS'(run_task_o));
          check_field("run_entry", expected_results[0].run_entry, run_entry_o);
          void'(expected_results.pop_front());
        end
      end
      // hold off once for a long stretch so the block backs up into its input
      if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
        holdoff_done = 1'b1;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready_i <= 1'b0;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        rx_stall_left = pick_gap(rx_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    int                   r;
    logic [ACT_W-1:0]     act;
    logic [ID_W-1:0]      id;
    logic [PRIO_BITS-1:0] prio;

    // empty table: nothing ready, every id is out of range
    queue_req(ACT_PICK, 3'd0, 8'd0, 32'h0);
    queue_req(ACT_DELETE, 3'd0, 8'd0, 32'h0);
    queue_req(ACT_RESUME, 3'd7, 8'd0, 32'hFFFF_FFFF);
    queue_req(ACT_CREATE, 3'd0, 8'd0, 32'h1234_5678);
    queue_req(ACT_CREATE, 3'd7, 8'd255, 32'hFFFF_FFFF);
    queue_req(ACT_CREATE, 3'd0, 8'd255, 32'h0000_0001);
    queue_req(ACT_CREATE, 3'd0, 8'd1, 32'h0);
    queue_req(ACT_SUSPEND, 3'd1, 8'd0, 32'h0);
    queue_req(ACT_SUSPEND, 3'd0, 8'd0, 32'h0);
    // suspend twice, then resume leaves the task suspended
    queue_req(ACT_SUSPEND, 3'd0, 8'd0, 32'h0);
    queue_req(ACT_RESUME, 3'd0, 8'd0, 32'h0);
    queue_req(ACT_RESUME, 3'd1, 8'd0, 32'h0);
    queue_req(ACT_SUSPEND, 3'd2, 8'd0, 32'h0);
    queue_req(ACT_CREATE, 3'd0, 8'd128, 32'hA5A5_5A5A);
    queue_req(ACT_CREATE, 3'd0, 8'd127, 32'h5A5A_A5A5);
    // resume of a deleted slot restores the state saved at suspend
    queue_req(ACT_SUSPEND, 3'd2, 8'd0, 32'h0);
    queue_req(ACT_DELETE, 3'd2, 8'd0, 32'h0);
    queue_req(ACT_RESUME, 3'd2, 8'd0, 32'h0);
    // a deleted slot still holds its priority against duplicates
    queue_req(ACT_DELETE, 3'd1, 8'd0, 32'h0);
    queue_req(ACT_CREATE, 3'd0, 8'd1, 32'h0);
    queue_req(ACT_CREATE, 3'd0, 8'd200, 32'h8000_0000);
    queue_req(ACT_CREATE, 3'd0, 8'd100, 32'h7FFF_FFFF);
    queue_req(ACT_CREATE, 3'd0, 8'd50, 32'hDEAD_0000);
    queue_req(ACT_CREATE, 3'd0, 8'd60, 32'h0000_BEEF);
    // full table is reported before a bad priority
    queue_req(ACT_CREATE, 3'd0, 8'd0, 32'h0);
    queue_req(ACT_UNUSED_FIRST, 3'd7, 8'd255, 32'hFFFF_FFFF);
    queue_req(ACT_UNUSED_MID, 3'd0, 8'd0, 32'h0);
    queue_req(ACT_UNUSED_LAST, 3'd5, 8'd9, 32'h0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 15) act = ACT_CREATE;
      else if (r < 30) act = ACT_DELETE;
      else if (r < 55) act = ACT_SUSPEND;
      else if (r < 80) act = ACT_RESUME;
      else if (r < 93) act = ACT_PICK;
      else act = ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
      r = $urandom_range(0, 99);
      // a small pool of priorities makes duplicates common
      if (r < 5) prio = '0;
      else if (r < 35) prio = PRIO_BITS'($urandom_range(1, 16));
      else prio = PRIO_BITS'($urandom_range(1, (1 << PRIO_BITS) - 1));
      // never resume a slot whose saved state was never written; suspend it instead
      if (act == ACT_RESUME && id < gen_count && !gen_suspended[id]) act = ACT_SUSPEND;
      queue_req(act, id, prio, $urandom);
    end

    while (items_accepted < items_queued || expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ptts_pkg.sv
rtl/ptts_ram.sv
rtl/ptts_walk.sv
rtl/priority_task_table_scheduler_core.sv
sim/testbench.sv
